>>> hdl/rrct_pkg.sv
package rrct_pkg;

    localparam int MAX_PROCESSES = 16;
    localparam int IDX_W  = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int CNT_W  = $clog2(MAX_PROCESSES + 1);
    localparam int DUR_W  = 16;
    localparam int TIME_W = 21;
    localparam int DIFF_W = 22;
    localparam int SUM_W  = 26;
    localparam int PN_W   = 5;

    localparam int S_DATA_W = 2 * DUR_W;
    localparam int M_FIELD_W = PN_W + DUR_W + 2 * DIFF_W + 2 * SUM_W;
    localparam int M_DATA_W = ((M_FIELD_W + 7) / 8) * 8;

    localparam logic [DUR_W-1:0] TIME_SLICE_RESET = DUR_W'(2);

    // commands from the sequencer
    typedef struct packed {
        logic load;
        logic clear;
        logic exec;
        logic next;
    } cmd_t;

    // status back to the sequencer
    typedef struct packed {
        logic load_end;
        logic more_work;
        logic completes;
        logic out_busy;
    } status_t;

endpackage

>>> hdl/rrct_ram.sv
module rrct_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> hdl/rrct_ctrl.sv
module rrct_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  rrct_pkg::status_t   status,
    output rrct_pkg::cmd_t      cmd
);

    localparam logic [1:0] ST_LOAD  = 2'd0;
    localparam logic [1:0] ST_CHECK = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;
    localparam logic [1:0] ST_NEXT  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign s_tready = (state_reg == ST_LOAD);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_LOAD: begin
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    if (status.load_end) begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                if (status.more_work) begin
                    state_next = ST_EXEC;
                end else begin
                    cmd.clear  = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_EXEC: begin
                // a finishing turn waits for the output register to free up
                if (!(status.completes && status.out_busy)) begin
                    cmd.exec   = 1'b1;
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT: begin
                cmd.next   = 1'b1;
                state_next = ST_CHECK;
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> hdl/rrct_datapath.sv
module rrct_datapath (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [rrct_pkg::DUR_W-1:0]     cfg_wr_data,
    input  logic [rrct_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [rrct_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                           m_tlast,
    input  rrct_pkg::cmd_t                 cmd,
    output rrct_pkg::status_t              status
);

    localparam int IDX_W  = rrct_pkg::IDX_W;
    localparam int CNT_W  = rrct_pkg::CNT_W;
    localparam int DUR_W  = rrct_pkg::DUR_W;
    localparam int TIME_W = rrct_pkg::TIME_W;
    localparam int DIFF_W = rrct_pkg::DIFF_W;
    localparam int SUM_W  = rrct_pkg::SUM_W;
    localparam int PN_W   = rrct_pkg::PN_W;

    logic [DUR_W-1:0]  time_slice_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  done_reg;
    logic [TIME_W-1:0] time_reg;
    logic [IDX_W-1:0]  scan_reg;
    logic              served_reg;
    logic              cmpl_reg;
    logic signed [DIFF_W-1:0] ta_reg;
    logic [DUR_W-1:0]  burst_lat_reg;
    logic [PN_W-1:0]   pn_reg;
    logic signed [SUM_W-1:0] ta_total_reg;
    logic signed [SUM_W-1:0] wt_total_reg;

    logic              m_valid_reg;
    logic [PN_W-1:0]   m_pn_reg;
    logic [DUR_W-1:0]  m_burst_reg;
    logic signed [DIFF_W-1:0] m_ta_reg;
    logic signed [DIFF_W-1:0] m_wt_reg;
    logic signed [SUM_W-1:0]  m_tas_reg;
    logic signed [SUM_W-1:0]  m_wts_reg;
    logic              m_last_reg;

    logic [DUR_W-1:0]  in_burst;
    logic [DUR_W-1:0]  in_arrival;
    logic [DUR_W-1:0]  burst_rd;
    logic [DUR_W-1:0]  arrival_rd;
    logic [DUR_W-1:0]  rem_rd;
    logic [DUR_W-1:0]  quantum;
    logic              rem_zero;
    logic              rem_fits;
    logic [CNT_W-1:0]  scan_plus;
    logic [IDX_W-1:0]  wr_addr;
    logic [IDX_W-1:0]  arr_rd_addr;
    logic              rem_wr_en;
    logic [DUR_W-1:0]  rem_wr_data;
    logic [TIME_W-1:0] time_done;
    logic signed [DIFF_W-1:0] ta_calc;
    logic signed [DIFF_W-1:0] wt_calc;
    logic signed [SUM_W-1:0]  tas_calc;
    logic signed [SUM_W-1:0]  wts_calc;

    assign in_burst   = s_tdata[DUR_W-1:0];
    assign in_arrival = s_tdata[2*DUR_W-1:DUR_W];

    assign quantum   = (time_slice_reg == '0) ? DUR_W'(1) : time_slice_reg;
    assign rem_zero  = (rem_rd == '0);
    assign rem_fits  = (rem_rd <= quantum);
    assign scan_plus = CNT_W'(scan_reg) + CNT_W'(1);

    assign wr_addr     = cmd.load ? count_reg[IDX_W-1:0] : scan_reg;
    assign arr_rd_addr = cmd.exec ? scan_plus[IDX_W-1:0] : scan_reg;
    assign rem_wr_en   = cmd.load || (cmd.exec && !rem_zero);
    assign rem_wr_data = cmd.load ? in_burst :
                         (rem_fits ? '0 : (rem_rd - quantum));

    assign time_done = time_reg + TIME_W'(rem_rd);
    assign ta_calc   = $signed({1'b0, time_done}) - $signed(DIFF_W'(arrival_rd));
    assign wt_calc   = ta_reg - $signed(DIFF_W'(burst_lat_reg));
    assign tas_calc  = ta_total_reg + SUM_W'(ta_reg);
    assign wts_calc  = wt_total_reg + SUM_W'(wt_calc);

    assign status.load_end  = s_tlast ||
                              (count_reg == CNT_W'(rrct_pkg::MAX_PROCESSES - 1));
    assign status.more_work = (done_reg < count_reg);
    assign status.completes = !rem_zero && rem_fits;
    assign status.out_busy  = m_valid_reg && !m_tready;

    rrct_ram #(.WIDTH(DUR_W), .DEPTH(rrct_pkg::MAX_PROCESSES)) u_burst_ram (
        .clk     (aclk),
        .wr_en   (cmd.load),
        .wr_addr (wr_addr),
        .wr_data (in_burst),
        .rd_addr (scan_reg),
        .rd_data (burst_rd)
    );

    rrct_ram #(.WIDTH(DUR_W), .DEPTH(rrct_pkg::MAX_PROCESSES)) u_arrival_ram (
        .clk     (aclk),
        .wr_en   (cmd.load),
        .wr_addr (wr_addr),
        .wr_data (in_arrival),
        .rd_addr (arr_rd_addr),
        .rd_data (arrival_rd)
    );

    rrct_ram #(.WIDTH(DUR_W), .DEPTH(rrct_pkg::MAX_PROCESSES)) u_remaining_ram (
        .clk     (aclk),
        .wr_en   (rem_wr_en),
        .wr_addr (wr_addr),
        .wr_data (rem_wr_data),
        .rd_addr (scan_reg),
        .rd_data (rem_rd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_slice_reg <= rrct_pkg::TIME_SLICE_RESET;
        end else if (cfg_wr_en) begin
            time_slice_reg <= cfg_wr_data;
        end
    end

    // list and simulation state
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            count_reg    <= '0;
            done_reg     <= '0;
            time_reg     <= '0;
            scan_reg     <= '0;
            served_reg   <= 1'b0;
            cmpl_reg     <= 1'b0;
            ta_total_reg <= '0;
            wt_total_reg <= '0;
        end else begin
            if (cmd.load) begin
                count_reg <= count_reg + CNT_W'(1);
                // zero-burst processes are done from the start
                if (in_burst == '0) begin
                    done_reg <= done_reg + CNT_W'(1);
                end
            end
            if (cmd.exec) begin
                cmpl_reg <= status.completes;
                if (!rem_zero) begin
                    served_reg <= 1'b1;
                    if (rem_fits) begin
                        time_reg <= time_done;
                        done_reg <= done_reg + CNT_W'(1);
                    end else begin
                        time_reg <= time_reg + TIME_W'(quantum);
                    end
                end
            end
            if (cmd.next) begin
                if (cmpl_reg) begin
                    ta_total_reg <= tas_calc;
                    wt_total_reg <= wts_calc;
                end
                if (scan_plus >= count_reg) begin
                    scan_reg   <= '0;
                    served_reg <= 1'b0;
                end else if (TIME_W'(arrival_rd) <= time_reg) begin
                    scan_reg <= scan_plus[IDX_W-1:0];
                end else if (!served_reg) begin
                    // idle cpu: jump ahead to the next arrival
                    time_reg <= TIME_W'(arrival_rd);
                    scan_reg <= scan_plus[IDX_W-1:0];
                end else begin
                    scan_reg   <= '0;
                    served_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            ta_reg        <= ta_calc;
            burst_lat_reg <= burst_rd;
            pn_reg        <= PN_W'(scan_plus);
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.next && cmpl_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.next && cmpl_reg) begin
            m_pn_reg    <= pn_reg;
            m_burst_reg <= burst_lat_reg;
            m_ta_reg    <= ta_reg;
            m_wt_reg    <= wt_calc;
            m_tas_reg   <= tas_calc;
            m_wts_reg   <= wts_calc;
            m_last_reg  <= (done_reg == count_reg);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {{(rrct_pkg::M_DATA_W - rrct_pkg::M_FIELD_W){1'b0}},
                       m_wts_reg, m_tas_reg, m_wt_reg, m_ta_reg,
                       m_burst_reg, m_pn_reg};

endmodule

>>> hdl/round_robin_completion_times_unit.sv
// channel   direction  signals                          contents
// cfg       in         cfg_wr_en, cfg_wr_data[15:0]     time slice
// s_        in         s_tvalid/s_tready/s_tdata/s_tlast  one process per beat
// m_        out        m_tvalid/m_tready/m_tdata/m_tlast  one completion per beat
//
// loading takes one beat per cycle; the beat with tlast, or the one that fills
// the list, starts the round-robin run, during which s_tready is low.
// each turn of the run steps through check, execute through the
// remaining-time ram, and advance the scan.
// a completing turn holds while the output register is still full.
// aresetn is synchronous; the list memories need no clearing after reset.
module round_robin_completion_times_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [rrct_pkg::DUR_W-1:0]     cfg_wr_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // burst_time, arrival_time
    input  logic [rrct_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // process_number, burst_echo, turnaround, waiting, turnaround_sum, waiting_sum
    output logic [rrct_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                           m_tlast
);

    rrct_pkg::cmd_t    cmd;
    rrct_pkg::status_t status;

    rrct_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rrct_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cmd         (cmd),
        .status      (status)
    );

endmodule
